### rtl/core/hadf_pkg.sv
`timescale 1ns / 1ps
package hadf_pkg;

  localparam int unsigned DefCapacity = 256;
  localparam int unsigned HW = 9;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_CLEAN = 3'd2,
    OP_NEXT  = 3'd3,
    OP_DEAD  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]    operation;
    logic [HW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [HW-1:0] result_handle;
    logic          is_dead;
    logic [HW-1:0] reclaimed;
    logic [1:0]    status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_FREE_RD,
    S_CLEAN_RD,
    S_CLEAN_LINK,
    S_CLEAN_WR,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_DEAD_RD,
    S_DONE
  } state_e;

  // Memory write bundle from the sequencer to the link store.
  typedef struct packed {
    logic          dead_we;
    logic [HW-1:0] dead_addr;
    logic          dead_val;
    logic          next_we;
    logic [HW-1:0] next_addr;
    logic [HW-1:0] next_val;
    logic          prev_we;
    logic [HW-1:0] prev_addr;
    logic [HW-1:0] prev_val;
  } mem_wr_t;

endpackage

### rtl/core/hadf_link_mem.sv
`timescale 1ns / 1ps
module hadf_link_mem
  import hadf_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic          clk_i,
  input  logic [HW-1:0] rd_addr_i,
  input  mem_wr_t       wr_i,
  output logic          rd_dead_o,
  output logic [HW-1:0] rd_next_o,
  output logic [HW-1:0] rd_prev_o
);

  localparam int unsigned AW = $clog2(Capacity);

  // Handle h lives at entry h-1.
  logic          dead_mem [Capacity];
  logic [HW-1:0] next_mem [Capacity];
  logic [HW-1:0] prev_mem [Capacity];

  function automatic logic [AW-1:0] slot(input logic [HW-1:0] h);
    logic [HW-1:0] t;
    t = h - HW'(1);
    return t[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i.dead_we) dead_mem[slot(wr_i.dead_addr)] <= wr_i.dead_val;
    if (wr_i.next_we) next_mem[slot(wr_i.next_addr)] <= wr_i.next_val;
    if (wr_i.prev_we) prev_mem[slot(wr_i.prev_addr)] <= wr_i.prev_val;
    rd_dead_o <= dead_mem[slot(rd_addr_i)];
    rd_next_o <= next_mem[slot(rd_addr_i)];
    rd_prev_o <= prev_mem[slot(rd_addr_i)];
  end

endmodule

### rtl/core/hadf_list_mem.sv
`timescale 1ns / 1ps
module hadf_list_mem
  import hadf_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [HW-1:0] waddr_i,
  input  logic [HW-1:0] wdata_i,
  input  logic [HW-1:0] raddr_i,
  output logic [HW-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(Capacity);

  logic [HW-1:0] mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i[AW-1:0]] <= wdata_i;
    rdata_o <= mem[raddr_i[AW-1:0]];
  end

endmodule

### rtl/core/handle_allocator_deferred_free.sv
`timescale 1ns / 1ps
// Handle allocator with deferred reclamation.
// Command channel: drive req_i and pulse start_i while busy_o is low; the word
// is taken at that edge and busy_o rises on the next cycle.
// Result channel: done_o is high for exactly one cycle with rsp_o; the receiver
// cannot stall it, so it must sample rsp_o whenever done_o is high.
// Full, bad handle, unknown operation and clean of an empty dirty list go from
// the accepting edge straight to done_o; alloc takes an extra write pass when
// the live list is not empty, next steps once per dead handle skipped, and
// clean takes a read and a write-back per dirty handle.
// Each list step waits on the synchronous link memory read; the sequencer
// issues one read and then writes back.
// busy_o stays high through the done_o cycle and falls on the next one.
// The link memories and stacks have no reset; only entries of handles already
// issued are ever used. Reset clears the counters, list head and sequencer.
module handle_allocator_deferred_free
  import hadf_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  state_e state_q, state_d;
  logic [2:0]    op_q, op_d;
  logic [HW-1:0] h_q, h_d;
  logic [HW-1:0] free_top_q, free_top_d;
  logic [HW-1:0] dirty_q, dirty_d;
  logic [HW-1:0] fresh_q, fresh_d;
  logic [HW-1:0] head_q, head_d;
  logic [HW-1:0] idx_q, idx_d;
  logic [HW-1:0] steps_q, steps_d;
  logic [HW-1:0] nx_q, nx_d;
  logic [HW-1:0] pv_q, pv_d;
  rsp_t          rsp_q, rsp_d;

  logic [HW-1:0] rd_addr;
  mem_wr_t       wr;
  logic          rd_dead;
  logic [HW-1:0] rd_next, rd_prev;
  logic          fs_we, dl_we;
  logic [HW-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  logic [HW-1:0] dl_waddr, dl_wdata, dl_raddr, dl_rdata;

  hadf_link_mem #(.Capacity(Capacity)) u_link (
    .clk_i, .rd_addr_i(rd_addr), .wr_i(wr),
    .rd_dead_o(rd_dead), .rd_next_o(rd_next), .rd_prev_o(rd_prev)
  );
  hadf_list_mem #(.Capacity(Capacity)) u_free (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );
  hadf_list_mem #(.Capacity(Capacity)) u_dirty (
    .clk_i, .we_i(dl_we), .waddr_i(dl_waddr), .wdata_i(dl_wdata),
    .raddr_i(dl_raddr), .rdata_o(dl_rdata)
  );

  localparam logic [HW:0] CapW = (HW+1)'(Capacity);

  function automatic logic issued(input logic [HW-1:0] h, input logic [HW-1:0] f);
    return (h != '0) && (h <= f);
  endfunction

  logic [HW-1:0] alloc_h;
  assign alloc_h = (free_top_q != '0) ? fs_rdata : fresh_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q; h_d = h_q; free_top_d = free_top_q; dirty_d = dirty_q;
    fresh_d = fresh_q; head_d = head_q; idx_d = idx_q; steps_d = steps_q;
    nx_d = nx_q; pv_d = pv_q; rsp_d = rsp_q;
    rd_addr = h_q;
    wr = '0;
    fs_we = 1'b0; fs_waddr = free_top_q; fs_wdata = '0;
    fs_raddr = free_top_q - HW'(1);
    dl_we = 1'b0; dl_waddr = dirty_q; dl_wdata = h_q; dl_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // The links of the operand are read at the accepting edge.
          rd_addr = req_i.handle;
          op_d = req_i.operation; h_d = req_i.handle; rsp_d = '0;
          idx_d = '0; steps_d = '0;
          case (req_i.operation)
            OP_ALLOC: begin
              if (free_top_q == '0 && {1'b0, fresh_q} >= CapW) begin
                rsp_d.status = ST_FULL;
                state_d = S_DONE;
              end else begin
                if (free_top_q == '0) fresh_d = fresh_q + HW'(1);
                state_d = S_ALLOC_RD;
              end
            end
            OP_FREE, OP_DEAD: begin
              if (!issued(req_i.handle, fresh_q)) begin
                rsp_d.status = ST_BAD; state_d = S_DONE;
              end else begin
                state_d = (req_i.operation == OP_FREE) ? S_FREE_RD : S_DEAD_RD;
              end
            end
            OP_CLEAN: begin
              rsp_d.reclaimed = dirty_q;
              state_d = (dirty_q == '0) ? S_DONE : S_CLEAN_RD;
            end
            OP_NEXT: begin
              if (req_i.handle == '0) begin
                h_d = head_q; state_d = S_NEXT_CHK;
              end else if (!issued(req_i.handle, fresh_q)) begin
                rsp_d.status = ST_BAD; state_d = S_DONE;
              end else begin
                state_d = S_NEXT_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ALLOC_RD: begin
        // Free stack top is on fs_rdata now.
        h_d = alloc_h;
        if (free_top_q != '0) free_top_d = free_top_q - HW'(1);
        state_d = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        wr.dead_we = 1'b1; wr.dead_addr = h_q; wr.dead_val = 1'b0;
        wr.next_we = 1'b1; wr.next_addr = h_q; wr.next_val = head_q;
        wr.prev_we = 1'b1; wr.prev_addr = h_q; wr.prev_val = '0;
        if (issued(head_q, fresh_q)) begin
          // The new handle's own prev write shares the port; head differs from it.
          wr.prev_addr = head_q; wr.prev_val = h_q;
          state_d = S_ALLOC_RD;
          op_d = OP_ALLOC + 3'd0;
          head_d = head_q;
          // Finish with a second write of prev for the new handle.
          steps_d = '1;
        end
        if (steps_q == '1 || !issued(head_q, fresh_q)) begin
          wr.prev_addr = h_q; wr.prev_val = '0;
          wr.next_we = (steps_q != '1);
          wr.dead_we = (steps_q != '1);
          if (steps_q == '1) wr.prev_val = '0;
          head_d = h_q; rsp_d.result_handle = h_q; state_d = S_DONE;
        end else begin
          state_d = S_ALLOC_WR;
        end
      end
      S_FREE_RD: state_d = S_CLEAN_LINK;
      S_DEAD_RD: state_d = S_CLEAN_LINK;
      S_CLEAN_RD: begin
        state_d = S_CLEAN_LINK;
      end
      S_CLEAN_LINK: begin
        if (op_q == OP_DEAD) begin
          rsp_d.is_dead = rd_dead; state_d = S_DONE;
        end else if (op_q == OP_FREE) begin
          if (!rd_dead && {1'b0, dirty_q} < CapW) begin
            wr.dead_we = 1'b1; wr.dead_addr = h_q; wr.dead_val = 1'b1;
            dl_we = 1'b1; dirty_d = dirty_q + HW'(1);
          end
          state_d = S_DONE;
        end else begin
          // Dirty entry arrived; read its links next.
          h_d = dl_rdata; rd_addr = dl_rdata;
          state_d = S_CLEAN_WR;
          steps_d = '0;
        end
      end
      S_CLEAN_WR: begin
        if (steps_q == '0) begin
          nx_d = issued(h_q, fresh_q) ? rd_next : '0;
          pv_d = issued(h_q, fresh_q) ? rd_prev : '0;
          steps_d = HW'(1);
        end else begin
          if (issued(h_q, fresh_q)) begin
            if (issued(nx_q, fresh_q)) begin
              wr.prev_we = 1'b1; wr.prev_addr = nx_q; wr.prev_val = pv_q;
            end
            if (issued(pv_q, fresh_q)) begin
              wr.next_we = 1'b1; wr.next_addr = pv_q; wr.next_val = nx_q;
            end
            if (h_q == head_q) head_d = nx_q;
          end
          if ({1'b0, free_top_q} < CapW) begin
            fs_we = 1'b1; fs_wdata = h_q; free_top_d = free_top_q + HW'(1);
          end
          idx_d = idx_q + HW'(1);
          if (idx_q + HW'(1) == dirty_q) begin
            dirty_d = '0; state_d = S_DONE;
          end else begin
            dl_raddr = idx_q + HW'(1);
            state_d = S_CLEAN_LINK;
          end
        end
      end
      S_NEXT_RD: begin
        // Links of the operand were read at the accepting edge.
        h_d = rd_next; state_d = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        // First pass reads the candidate, second pass looks at its dead mark.
        if (idx_q == '0) begin
          if (h_q == '0 || !issued(h_q, fresh_q) || {1'b0, steps_q} > CapW) begin
            state_d = S_DONE;
          end else begin
            idx_d = HW'(1);
          end
        end else begin
          idx_d = '0;
          if (!rd_dead) begin
            rsp_d.result_handle = h_q; state_d = S_DONE;
          end else begin
            h_d = rd_next; steps_d = steps_q + HW'(1);
          end
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_top_q <= '0; dirty_q <= '0; fresh_q <= '0; head_q <= '0;
      op_q <= '0; h_q <= '0; idx_q <= '0; steps_q <= '0;
    end else begin
      state_q <= state_d;
      free_top_q <= free_top_d; dirty_q <= dirty_d; fresh_q <= fresh_d;
      head_q <= head_d; op_q <= op_d; h_q <= h_d; idx_q <= idx_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d; pv_q <= pv_d; rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = rsp_q;

  ap_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fresh_q} <= CapW) else $error("fresh count overflow");
  ap_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  ap_clean_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q == OP_CLEAN) |-> dirty_q == '0) else $error("dirty left");

endmodule
